>>> hw/rtl/bim_pkg.sv
// Shared types, constants and helpers for the broadcast index mapper.
// No dependencies; used by broadcast_index_mapper.
package bim_pkg;

	localparam int NUM_AXES  = 7;
	localparam int AXIS_BITS = 9;
	localparam int REG_W     = 63;
	localparam int POS_W     = 56;
	localparam int IDX_W     = 2;

	// quotient bits resolved per divider stage
	localparam int DIV_BITS  = 8;
	localparam int DIV_STEPS = (POS_W + DIV_BITS - 1) / DIV_BITS;
	localparam int DIV_STG   = NUM_AXES * DIV_STEPS;
	localparam int NUM_STG   = DIV_STG + NUM_AXES;

	// register indexes
	localparam logic [IDX_W-1:0] REG_OUT   = 2'd0;
	localparam logic [IDX_W-1:0] REG_LEFT  = 2'd1;
	localparam logic [IDX_W-1:0] REG_RIGHT = 2'd2;

	typedef struct packed {
		logic [POS_W-1:0]                    q;
		logic [AXIS_BITS-1:0]                rem;
		logic [NUM_AXES-1:0][AXIS_BITS-1:0]  coord;
		logic [POS_W-1:0]                    li;
		logic [POS_W-1:0]                    ri;
		logic                                inr;
	} stage_t;

	// axis size field k; zero and fields beyond the register read as 1
	function automatic logic [AXIS_BITS-1:0] axis_size(input logic [REG_W-1:0] r,
		input int k);
		logic [AXIS_BITS-1:0] f;
		f = '0;
		for (int b = 0; b < AXIS_BITS; b++) begin
			if (k * AXIS_BITS + b < REG_W) begin
				f[b] = r[k * AXIS_BITS + b];
			end
		end
		if (f == '0) begin
			f = {{(AXIS_BITS-1){1'b0}}, 1'b1};
		end
		return f;
	endfunction

	// every axis size set to 1
	function automatic logic [REG_W-1:0] reg_ones();
		logic [REG_W-1:0] v;
		v = '0;
		for (int k = 0; k < NUM_AXES; k++) begin
			if (k * AXIS_BITS < REG_W) begin
				v[k * AXIS_BITS] = 1'b1;
			end
		end
		return v;
	endfunction

endpackage

>>> hw/rtl/broadcast_index_mapper.sv
// Broadcast index mapper: flat output position to two operand element indices.
// Depends on bim_pkg.
//
// Usage: a position request enters on in_valid/in_stall; one result request
// (left_index, right_index, in_range) leaves on out_valid/out_stall.
// The position is split into seven mixed-radix digits by a pipelined
// restoring divider (eight quotient bits per stage, seven stages per axis,
// innermost axis first), then both operand indices are rebuilt by one
// multiply-add stage per axis.
// Stages: 49 divider stages and 7 recombine stages, the last of which is the
// output register.
// Throughput: one request per cycle while the output is not stalled.
// When the receiver stalls a held result, the whole pipeline freezes and
// in_stall rises; bubbles are not squeezed out while frozen.
// Configuration: cfg_we writes register cfg_index (0 output sizes, 1 left,
// 2 right sizes); write only while the block is empty.
// Reset: all axis sizes become 1 and the pipeline empties.
module broadcast_index_mapper (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bim_pkg::IDX_W-1:0]     cfg_index,
	input  logic [bim_pkg::REG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bim_pkg::POS_W-1:0]     position,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bim_pkg::POS_W-1:0]     left_index,
	output logic [bim_pkg::POS_W-1:0]     right_index,
	output logic                          in_range
);

	logic [bim_pkg::REG_W-1:0] out_sizes_q;
	logic [bim_pkg::REG_W-1:0] left_sizes_q;
	logic [bim_pkg::REG_W-1:0] right_sizes_q;

	logic                      vld_s [bim_pkg::NUM_STG];
	bim_pkg::stage_t           dat_s [bim_pkg::NUM_STG];
	bim_pkg::stage_t           src   [bim_pkg::NUM_STG];
	bim_pkg::stage_t           nxt   [bim_pkg::NUM_STG];
	logic                      en;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_sizes_q   <= bim_pkg::reg_ones();
			left_sizes_q  <= bim_pkg::reg_ones();
			right_sizes_q <= bim_pkg::reg_ones();
		end else if (cfg_we) begin
			case (cfg_index)
				bim_pkg::REG_OUT:   out_sizes_q   <= cfg_data;
				bim_pkg::REG_LEFT:  left_sizes_q  <= cfg_data;
				bim_pkg::REG_RIGHT: right_sizes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// global advance: frozen only when the output holds a stalled result
	assign en       = !(vld_s[bim_pkg::NUM_STG-1] && out_stall);
	assign in_stall = !en;

	// stage 0 source
	always_comb begin
		src[0]   = '0;
		src[0].q = position;
	end

	for (genvar j = 1; j < bim_pkg::NUM_STG; j++) begin : g_src
		assign src[j] = dat_s[j-1];
	end

	for (genvar j = 0; j < bim_pkg::NUM_STG; j++) begin : g_stg
		if (j < bim_pkg::DIV_STG) begin : g_div
			localparam int AX = bim_pkg::NUM_AXES - 1 - j / bim_pkg::DIV_STEPS;
			localparam int ST = j % bim_pkg::DIV_STEPS;
			localparam int NB = (bim_pkg::POS_W - ST * bim_pkg::DIV_BITS
				< bim_pkg::DIV_BITS) ? bim_pkg::POS_W - ST * bim_pkg::DIV_BITS
				: bim_pkg::DIV_BITS;
			logic [bim_pkg::POS_W-1:0]     q;
			logic [bim_pkg::AXIS_BITS-1:0] r;
			logic [bim_pkg::AXIS_BITS:0]   t;
			logic [bim_pkg::AXIS_BITS-1:0] d;

			// restoring division, quotient bits shift in behind the dividend
			always_comb begin
				nxt[j] = src[j];
				d = bim_pkg::axis_size(out_sizes_q, AX);
				q = src[j].q;
				r = (ST == 0) ? '0 : src[j].rem;
				t = '0;
				for (int b = 0; b < NB; b++) begin
					t = {r, q[bim_pkg::POS_W-1]};
					q = {q[bim_pkg::POS_W-2:0], 1'b0};
					if (t >= {1'b0, d}) begin
						t = t - {1'b0, d};
						q[0] = 1'b1;
					end
					r = t[bim_pkg::AXIS_BITS-1:0];
				end
				nxt[j].q   = q;
				nxt[j].rem = r;
				if (ST == bim_pkg::DIV_STEPS - 1) begin
					nxt[j].coord[AX] = r;
				end
				if (j == bim_pkg::DIV_STG - 1) begin
					nxt[j].inr = (q == '0);
				end
			end
		end else begin : g_cmb
			localparam int K = j - bim_pkg::DIV_STG;
			logic [bim_pkg::AXIS_BITS-1:0]          sl;
			logic [bim_pkg::AXIS_BITS-1:0]          sr;
			logic [bim_pkg::POS_W+bim_pkg::AXIS_BITS-1:0] pl;
			logic [bim_pkg::POS_W+bim_pkg::AXIS_BITS-1:0] pr;
			logic [bim_pkg::POS_W-1:0]              al;
			logic [bim_pkg::POS_W-1:0]              ar;

			// index = index * size + coordinate; broadcast axes add zero
			always_comb begin
				nxt[j] = src[j];
				sl = bim_pkg::axis_size(left_sizes_q, K);
				sr = bim_pkg::axis_size(right_sizes_q, K);
				pl = src[j].li * sl;
				pr = src[j].ri * sr;
				al = (sl == {{(bim_pkg::AXIS_BITS-1){1'b0}}, 1'b1}) ? '0 :
					{{(bim_pkg::POS_W-bim_pkg::AXIS_BITS){1'b0}}, src[j].coord[K]};
				ar = (sr == {{(bim_pkg::AXIS_BITS-1){1'b0}}, 1'b1}) ? '0 :
					{{(bim_pkg::POS_W-bim_pkg::AXIS_BITS){1'b0}}, src[j].coord[K]};
				nxt[j].li = pl[bim_pkg::POS_W-1:0] + al;
				nxt[j].ri = pr[bim_pkg::POS_W-1:0] + ar;
			end
		end

		// pipeline registers
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (en) begin
				vld_s[j] <= (j == 0) ? in_valid : vld_s[(j == 0) ? 0 : j - 1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dat_s[j] <= nxt[j];
			end
		end
	end

	assign out_valid   = vld_s[bim_pkg::NUM_STG-1];
	assign left_index  = dat_s[bim_pkg::NUM_STG-1].li;
	assign right_index = dat_s[bim_pkg::NUM_STG-1].ri;
	assign in_range    = dat_s[bim_pkg::NUM_STG-1].inr;

	// an accepted request enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s[0])
		else $error("accepted request lost at pipeline entry");

	// a request ahead of the output reaches it on advance
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s[bim_pkg::NUM_STG-2] |=> out_valid)
		else $error("request lost before output stage");

	// a stalled result stays presented
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(left_index) && $stable(right_index))
		else $error("stalled result changed");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for broadcast_index_mapper: directed and random position requests
// checked against a behavioral index mapper. Depends on bim_pkg and the RTL.
module testbench;

	typedef logic [bim_pkg::POS_W-1:0] pos_t;

	// index past the register list, written to check that it is ignored
	localparam logic [bim_pkg::IDX_W-1:0] REG_NONE = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [bim_pkg::IDX_W-1:0] cfg_index;
	logic [bim_pkg::REG_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [bim_pkg::POS_W-1:0] position;
	logic out_valid;
	logic out_stall;
	logic [bim_pkg::POS_W-1:0] left_index;
	logic [bim_pkg::POS_W-1:0] right_index;
	logic in_range;

	typedef struct {
		logic [bim_pkg::POS_W-1:0] left;
		logic [bim_pkg::POS_W-1:0] right;
		logic inr;
	} index_pair_t;

	index_pair_t pending_pairs[$];
	logic [bim_pkg::REG_W-1:0] out_sizes, left_sizes, right_sizes;
	int errors = 0;
	int sent = 0;
	int checked = 0;
	longint cycles = 0;
	logic stall_en = 1'b1;

	broadcast_index_mapper u_top (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// generous cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// size field k, zero reads as one
	function automatic longint unsigned field_size(logic [bim_pkg::REG_W-1:0] r, int k);
		logic [bim_pkg::AXIS_BITS-1:0] f;
		f = r[k*bim_pkg::AXIS_BITS +: bim_pkg::AXIS_BITS];
		return (f == 0) ? 1 : longint'(f);
	endfunction

	function automatic logic [bim_pkg::POS_W-1:0] rebuild_index(
		logic [bim_pkg::REG_W-1:0] r, longint unsigned crd[bim_pkg::NUM_AXES]);
		longint unsigned acc;
		longint unsigned s;
		acc = 0;
		for (int k = 0; k < bim_pkg::NUM_AXES; k++) begin
			s = field_size(r, k);
			acc = acc * s + ((s == 1) ? 0 : crd[k]);
		end
		return acc[bim_pkg::POS_W-1:0];
	endfunction

	function automatic index_pair_t map_position(logic [bim_pkg::POS_W-1:0] p);
		longint unsigned crd[bim_pkg::NUM_AXES];
		longint unsigned q;
		longint unsigned d;
		index_pair_t r;
		q = p;
		for (int k = bim_pkg::NUM_AXES - 1; k >= 0; k--) begin
			d = field_size(out_sizes, k);
			crd[k] = q % d;
			q = q / d;
		end
		r.left = rebuild_index(left_sizes, crd);
		r.right = rebuild_index(right_sizes, crd);
		r.inr = (q == 0);
		return r;
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
	endfunction

	// result stall: random, sometimes long
	int stall_left = 0;
	always @(posedge clk) begin
		if (!stall_en) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 3) == 0) begin
			stall_left <= gap_len();
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result checker
	always @(posedge clk) begin
		index_pair_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pairs.size() == 0) begin
				$error("unexpected result request");
				errors++;
			end else begin
				e = pending_pairs.pop_front();
				checked++;
				if (left_index !== e.left) begin
					$error("left_index exp %h got %h", e.left, left_index);
					errors++;
				end
				if (right_index !== e.right) begin
					$error("right_index exp %h got %h", e.right, right_index);
					errors++;
				end
				if (in_range !== e.inr) begin
					$error("in_range exp %b got %b", e.inr, in_range);
					errors++;
				end
			end
		end
	end

	// valid stays high between back-to-back requests; it drops only for a gap
	task automatic send_position(logic [bim_pkg::POS_W-1:0] p, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		position <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_pairs.push_back(map_position(p));
		sent++;
	endtask

	// config write while the pipeline is empty
	task automatic write_sizes(logic [bim_pkg::REG_W-1:0] o, logic [bim_pkg::REG_W-1:0] l,
		logic [bim_pkg::REG_W-1:0] r);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= bim_pkg::REG_OUT;
		cfg_data <= o;
		@(posedge clk);
		cfg_index <= bim_pkg::REG_LEFT;
		cfg_data <= l;
		@(posedge clk);
		cfg_index <= bim_pkg::REG_RIGHT;
		cfg_data <= r;
		@(posedge clk);
		cfg_index <= REG_NONE;
		cfg_data <= '1;
		@(posedge clk);
		cfg_we <= 1'b0;
		out_sizes = o;
		left_sizes = l;
		right_sizes = r;
	endtask

	function automatic logic [bim_pkg::REG_W-1:0] pack_sizes(int s[bim_pkg::NUM_AXES]);
		logic [bim_pkg::REG_W-1:0] v;
		v = '0;
		for (int k = 0; k < bim_pkg::NUM_AXES; k++)
			v[k*bim_pkg::AXIS_BITS +: bim_pkg::AXIS_BITS] = s[k][bim_pkg::AXIS_BITS-1:0];
		return v;
	endfunction

	// random shape; operands mostly broadcast or match the output axis, the right one sometimes takes a random size
	task automatic random_shape(int max_axis);
		int o[bim_pkg::NUM_AXES], l[bim_pkg::NUM_AXES], r[bim_pkg::NUM_AXES];
		for (int k = 0; k < bim_pkg::NUM_AXES; k++) begin
			o[k] = $urandom_range(0, max_axis);
			l[k] = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1) : o[k];
			r[k] = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 1) : o[k];
			if ($urandom_range(0, 15) == 0) r[k] = $urandom_range(0, 511);
		end
		write_sizes(pack_sizes(o), pack_sizes(l), pack_sizes(r));
	endtask

	function automatic longint unsigned volume();
		longint unsigned v;
		v = 1;
		for (int k = 0; k < bim_pkg::NUM_AXES; k++) v = v * field_size(out_sizes, k);
		return v;
	endfunction

	task automatic test_reset_sizes();
		send_position('0, 1'b0);
		send_position(56'd1, 1'b0);
		send_position('1, 1'b0);
	endtask

	// extremes: all 256, raw all-ones registers (all 511), all 3, and all-zero operand registers
	task automatic test_extreme_sizes();
		int s[bim_pkg::NUM_AXES];
		logic [bim_pkg::POS_W-1:0] pos;
		foreach (s[k]) s[k] = 256;
		write_sizes(pack_sizes(s), pack_sizes(s), '0);
		send_position('0, 1'b0);
		send_position('1, 1'b0);
		pos = pos_t'(volume() - 1);
		send_position(pos, 1'b0);
		send_position(56'h55_5555_5555_5555, 1'b0);
		write_sizes('1, '1, '1);
		send_position('1, 1'b0);
		send_position(56'hAA_AAAA_AAAA_AAAA, 1'b0);
		send_position(56'd12345, 1'b0);
		foreach (s[k]) s[k] = 3;
		write_sizes(pack_sizes(s), '0, pack_sizes(s));
		pos = pos_t'(volume());
		send_position(pos, 1'b0);
		send_position(pos - 1'b1, 1'b0);
		send_position(56'd7, 1'b0);
	endtask

	// mostly small shapes, every third shape up to 511; positions mostly in range
	task automatic test_random_positions(int n);
		logic [bim_pkg::POS_W-1:0] pos;
		longint unsigned vol;
		for (int i = 0; i < n; i++) begin
			if (i % 40 == 0) random_shape((i % 120 == 0) ? 511 : 8);
			vol = volume();
			case ($urandom_range(0, 5))
				0: pos = pos_t'({$urandom, $urandom});
				1: pos = pos_t'(vol);
				default: pos = pos_t'({$urandom, $urandom} % vol);
			endcase
			send_position(pos, (i / 100) % 2 == 0);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bim_pkg::REG_OUT;
		cfg_data = '0;
		in_valid = 1'b0;
		position = '0;
		out_sizes = bim_pkg::reg_ones();
		left_sizes = bim_pkg::reg_ones();
		right_sizes = bim_pkg::reg_ones();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_sizes();
		test_extreme_sizes();
		test_random_positions(600);
		in_valid <= 1'b0;
		while (pending_pairs.size() != 0) @(posedge clk);
		stall_en = 1'b0;
		repeat (80) @(posedge clk);
		$display("covered %0d position requests, %0d results checked", sent, checked);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule

>>> sim.f
hw/rtl/bim_pkg.sv
hw/rtl/broadcast_index_mapper.sv
tb/testbench.sv
